@@ rtl/imhq_pkg.sv @@
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int ID_BITS    = 10;
  localparam int ID_SPACE   = 1024;
  localparam int COUNT_BITS = 11;
  localparam int OUT_KEY_BITS = 32;

  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_EXTRACT  = 2'd1;
  localparam logic [1:0] ACT_DECREASE = 2'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_ERR,
    OP_INS,
    OP_DEC,
    OP_UP_RD,
    OP_UP_MOVE,
    OP_DN_RD,
    OP_DN_LEFT,
    OP_DN_RIGHT,
    OP_DN_MOVE,
    OP_PLACE,
    OP_RD_TOP,
    OP_EX_TOP,
    OP_EX_LAST
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DN_CMP,
    S_PLACE,
    S_EX_TOP,
    S_EX_LAST,
    S_FIN
  } state_t;

  typedef struct packed {
    op_t     op;
    status_t st;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       clr_last;
    logic       pos_nz;
    logic       pos_gt_size;
    logic       size_zero;
    logic       size_full;
    logic       size_gt1;
    logic       slot_gt1;
    logic       up_less;
    logic       c_gt_size;
    logic       has_right;
    logic       dn_less;
    logic       out_free;
  } flags_t;

endpackage

@@ rtl/imhq_if.sv @@
// ----------------------------------------------------------------------------
// imhq_req_if / imhq_rsp_if
// Valid/ready channels for requests and results of the heap queue.
// ----------------------------------------------------------------------------
interface imhq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  item_id;
  logic [31:0] item_key;
  modport source (output valid, action, item_id, item_key, input ready);
  modport sink (input valid, action, item_id, item_key, output ready);
endinterface

interface imhq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  min_id;
  logic [31:0] min_key;
  logic        now_empty;
  logic [10:0] item_count;
  modport source (output valid, status, min_id, min_key, now_empty, item_count,
                  input ready);
  modport sink (input valid, status, min_id, min_key, now_empty, item_count,
                output ready);
endinterface

@@ rtl/imhq_ram.sv @@
// ----------------------------------------------------------------------------
// imhq_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/imhq_ctrl.sv @@
// ----------------------------------------------------------------------------
// imhq_ctrl
// Sequencer for insert, extract and decrease-key with sift up and down.
// ----------------------------------------------------------------------------
module imhq_ctrl import imhq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_ready,
  input  flags_t flags,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.st       = ST_OK;
    cmd.load_out = 1'b0;
    req_ready    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (flags.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = OP_ACCEPT;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_FIN;
        case (flags.act)
          ACT_INSERT: begin
            if (flags.pos_nz) begin
              cmd.op = OP_ERR;
              cmd.st = ST_PRESENT;
            end else if (flags.size_full) begin
              cmd.op = OP_ERR;
              cmd.st = ST_FULL;
            end else begin
              cmd.op     = OP_INS;
              state_next = S_UP_RD;
            end
          end
          ACT_EXTRACT: begin
            if (flags.size_zero) begin
              cmd.op = OP_ERR;
              cmd.st = ST_EMPTY;
            end else begin
              cmd.op     = OP_RD_TOP;
              state_next = S_EX_TOP;
            end
          end
          ACT_DECREASE: begin
            if (!flags.pos_nz || flags.pos_gt_size) begin
              cmd.op = OP_ERR;
              cmd.st = ST_ABSENT;
            end else begin
              cmd.op     = OP_DEC;
              state_next = S_UP_RD;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_UP_RD: begin
        if (flags.slot_gt1) begin
          cmd.op     = OP_UP_RD;
          state_next = S_UP_CMP;
        end else begin
          state_next = (flags.act == ACT_INSERT) ? S_PLACE : S_DN_RD;
        end
      end
      S_UP_CMP: begin
        if (flags.up_less) begin
          cmd.op     = OP_UP_MOVE;
          state_next = S_UP_RD;
        end else begin
          state_next = (flags.act == ACT_INSERT) ? S_PLACE : S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (flags.c_gt_size) begin
          state_next = S_PLACE;
        end else begin
          cmd.op     = OP_DN_RD;
          state_next = S_DN_LEFT;
        end
      end
      S_DN_LEFT: begin
        cmd.op     = OP_DN_LEFT;
        state_next = flags.has_right ? S_DN_RIGHT : S_DN_CMP;
      end
      S_DN_RIGHT: begin
        cmd.op     = OP_DN_RIGHT;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (flags.dn_less) begin
          cmd.op     = OP_DN_MOVE;
          state_next = S_DN_RD;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.op     = OP_PLACE;
        state_next = S_FIN;
      end
      S_EX_TOP: begin
        cmd.op     = OP_EX_TOP;
        state_next = flags.size_gt1 ? S_EX_LAST : S_FIN;
      end
      S_EX_LAST: begin
        cmd.op     = OP_EX_LAST;
        state_next = S_DN_RD;
      end
      S_FIN: begin
        if (flags.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/imhq_dp.sv @@
// ----------------------------------------------------------------------------
// imhq_dp
// Heap and position memories, the moving item and the result register.
// ----------------------------------------------------------------------------
module imhq_dp import imhq_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output flags_t                  flags,
  input  logic [1:0]              req_action,
  input  logic [ID_BITS-1:0]      req_item_id,
  input  logic [31:0]             req_item_key,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic [2:0]              rsp_status,
  output logic [ID_BITS-1:0]      rsp_min_id,
  output logic [OUT_KEY_BITS-1:0] rsp_min_key,
  output logic                    rsp_now_empty,
  output logic [COUNT_BITS-1:0]   rsp_item_count
);

  localparam int SW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int HW = ID_BITS + KEY_BITS;

  logic [SW-1:0]       size;
  logic [SW-1:0]       slot;
  logic [SW:0]         child;
  logic [1:0]          act;
  logic [ID_BITS-1:0]  in_id;
  logic [KEY_BITS-1:0] in_key;
  logic [ID_BITS-1:0]  cid;
  logic [KEY_BITS-1:0] ckey;
  logic [ID_BITS-1:0]  lid;
  logic [KEY_BITS-1:0] lkey;
  logic [ID_BITS-1:0]  min_id;
  logic [KEY_BITS-1:0] min_key;
  status_t             status;
  logic [ID_BITS-1:0]  clr_cnt;

  logic                heap_we;
  logic [AW-1:0]       heap_waddr;
  logic [HW-1:0]       heap_wdata;
  logic [AW-1:0]       heap_raddr;
  logic [HW-1:0]       heap_q;
  logic [ID_BITS-1:0]  q_id;
  logic [KEY_BITS-1:0] q_key;
  logic                pos_we;
  logic [ID_BITS-1:0]  pos_waddr;
  logic [SW-1:0]       pos_wdata;
  logic [SW-1:0]       pos_q;
  logic [SW:0]         left_of_slot;

  assign q_id         = heap_q[HW-1:KEY_BITS];
  assign q_key        = heap_q[KEY_BITS-1:0];
  assign left_of_slot = {slot, 1'b0};

  imhq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_q)
  );

  imhq_ram #(.WIDTH(SW), .DEPTH(ID_SPACE)) u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (req_item_id),
    .rdata (pos_q)
  );

  // Slot numbers are 1-based; the heap memory is addressed by slot minus one.
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = AW'(slot - SW'(1));
    heap_wdata = {cid, ckey};
    heap_raddr = AW'((slot >> 1) - SW'(1));
    pos_we     = 1'b0;
    pos_waddr  = cid;
    pos_wdata  = slot;
    case (cmd.op)
      OP_CLEAR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_cnt;
        pos_wdata = '0;
      end
      OP_UP_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = heap_q;
        pos_we     = 1'b1;
        pos_waddr  = q_id;
      end
      OP_DN_RD: begin
        heap_raddr = AW'(left_of_slot - (SW + 1)'(1));
      end
      OP_DN_LEFT: begin
        heap_raddr = AW'(child);
      end
      OP_DN_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = {lid, lkey};
        pos_we     = 1'b1;
        pos_waddr  = lid;
      end
      OP_PLACE: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
      end
      OP_RD_TOP: begin
        heap_raddr = '0;
      end
      OP_EX_TOP: begin
        heap_raddr = AW'(size - SW'(1));
        pos_we     = 1'b1;
        pos_waddr  = q_id;
        pos_wdata  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= '0;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          clr_cnt <= clr_cnt + ID_BITS'(1);
        end
        OP_ACCEPT: begin
          act     <= req_action;
          in_id   <= req_item_id;
          in_key  <= KEY_BITS'(req_item_key);
          status  <= ST_OK;
          min_id  <= '0;
          min_key <= '0;
        end
        OP_ERR: begin
          status <= cmd.st;
        end
        OP_INS: begin
          size <= SW'(size + SW'(1));
          slot <= SW'(size + SW'(1));
          cid  <= in_id;
          ckey <= in_key;
        end
        OP_DEC: begin
          slot <= pos_q;
          cid  <= in_id;
          ckey <= in_key;
        end
        OP_UP_MOVE: begin
          slot <= slot >> 1;
        end
        OP_DN_RD: begin
          child <= left_of_slot;
        end
        OP_DN_LEFT: begin
          lid  <= q_id;
          lkey <= q_key;
        end
        OP_DN_RIGHT: begin
          // The right child wins only when strictly smaller than the left.
          if (q_key < lkey) begin
            child <= child + (SW + 1)'(1);
            lid   <= q_id;
            lkey  <= q_key;
          end
        end
        OP_DN_MOVE: begin
          slot <= SW'(child);
        end
        OP_EX_TOP: begin
          min_id  <= q_id;
          min_key <= q_key;
          size    <= size - SW'(1);
        end
        OP_EX_LAST: begin
          cid  <= q_id;
          ckey <= q_key;
          slot <= SW'(1);
        end
        default: begin
        end
      endcase
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_status     <= status;
      rsp_min_id     <= min_id;
      rsp_min_key    <= OUT_KEY_BITS'(min_key);
      rsp_now_empty  <= (size == '0);
      rsp_item_count <= COUNT_BITS'(size);
    end
  end

  always_comb begin
    flags.act         = act;
    flags.clr_last    = (clr_cnt == ID_BITS'(ID_SPACE - 1));
    flags.pos_nz      = (pos_q != '0);
    flags.pos_gt_size = (pos_q > size);
    flags.size_zero   = (size == '0);
    flags.size_full   = (size >= SW'(CAPACITY));
    flags.size_gt1    = (size > SW'(1));
    flags.slot_gt1    = (slot > SW'(1));
    flags.up_less     = (ckey < q_key);
    flags.c_gt_size   = (left_of_slot > (SW + 1)'(size));
    flags.has_right   = (child < (SW + 1)'(size));
    flags.dn_less     = (lkey < ckey);
    flags.out_free    = !rsp_valid || rsp_ready;
  end

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    size <= SW'(CAPACITY))
    else $error("heap size beyond capacity");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten while still pending");

  a_up_root: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_UP_MOVE) |-> (slot > SW'(1)))
    else $error("sift up moved past the root");

  a_down_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DN_MOVE) |-> (child <= (SW + 1)'(size)))
    else $error("sift down chose a child beyond the heap");

endmodule

@@ rtl/indexed_min_heap_queue_top.sv @@
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top
// Indexed binary min-heap with insert, extract-minimum and decrease-key.
// ----------------------------------------------------------------------------
//   channel  dir  handshake     payload
//   req      in   valid/ready   action, item_id, item_key
//   rsp      out  valid/ready   status, min_id, min_key, now_empty, item_count
//
// One request at a time. After acceptance the request is checked; an error
// or no-op finishes there, extracting the last item only reads the top, and
// otherwise the item sifts up (insert, decrease-key) and then down
// (decrease-key, extract). The heap memory has a single read port, read once
// per parent and child, which paces each sift step. After reset a clearing
// pass writes the whole position table before the first request; a stalled
// result holds only the finish of the following request.
module indexed_min_heap_queue_top import imhq_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 32
) (
  input logic       clk,
  input logic       rst,
  imhq_req_if.sink  req,
  imhq_rsp_if.source rsp
);

  cmd_t   cmd;
  flags_t flags;

  imhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  imhq_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .flags          (flags),
    .req_action     (req.action),
    .req_item_id    (req.item_id),
    .req_item_key   (req.item_key),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_min_id     (rsp.min_id),
    .rsp_min_key    (rsp.min_key),
    .rsp_now_empty  (rsp.now_empty),
    .rsp_item_count (rsp.item_count)
  );

endmodule
